// ===== rtl/biquad_pkg.sv =====
`timescale 1ns / 1ps

package biquad_pkg;

  // port field widths
  localparam int FIELD_W   = 32;
  localparam int COEF_W    = 18;
  localparam int IDX_W     = 3;
  localparam int NUM_COEFS = 5;

  // register indexes
  localparam logic [IDX_W-1:0] REG_A0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_A1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_A2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_B1 = 3'd3;
  localparam logic [IDX_W-1:0] REG_B2 = 3'd4;

  // sequencer steps: products issued at steps 0..9, each summed in the next cycle
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_S1_X0  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_S1_X1  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_S1_X2  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_S1_Y1  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_S1_Y2  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_S2_X1  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_S2_X2  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_S2_Y1  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_S2_Y2  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_S2_X0  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_LAST   = 4'd10;

  // accumulator restarts and result capture points
  localparam logic [STEP_W-1:0] ACC_S1_FIRST = 4'd1;
  localparam logic [STEP_W-1:0] ACC_S2_FIRST = 4'd6;
  localparam logic [STEP_W-1:0] CAP_S1       = 4'd5;
  localparam logic [STEP_W-1:0] CAP_S2       = 4'd10;

  typedef struct packed {
    logic add;
    logic clear;
  } mac_ctrl_t;

endpackage

// ===== rtl/biquad_if.sv =====
`timescale 1ns / 1ps

interface biquad_in_if;
  import biquad_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface biquad_out_if;
  import biquad_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface biquad_cfg_if;
  import biquad_pkg::*;
  logic                     valid;
  logic                     ready;
  logic        [IDX_W-1:0]  index;
  logic signed [COEF_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/two_section_biquad_bandpass.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake     payload
// in_ch    in   valid/ready   sample_in  (32b signed)
// out_ch   out  valid/ready   sample_out (32b signed)
// cfg      in   valid/ready   index (3b), wdata (18b signed)
//
// each word passes through accept, ten products plus one add on the shared
// multiply-accumulate unit, then a load into the output register
// in_ch.ready is high only while idle; cfg.ready is always high
// a held output word does not block acceptance of the next word, but that
// word's final load waits for the output register, keeping in_ch.ready low
// reset (synchronous) clears coefficients, all histories and the output valid

module two_section_biquad_bandpass import biquad_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 14
) (
  input  logic          clk,
  input  logic          rst,
  biquad_in_if.sink     in_ch,
  biquad_out_if.source  out_ch,
  biquad_cfg_if.sink    cfg
);

  mac_ctrl_t                    mac_ctrl;
  logic signed [COEF_W-1:0]     coef_op;
  logic signed [DATA_WIDTH-1:0] data_op;
  logic signed [DATA_WIDTH-1:0] mac_result;
  logic signed [DATA_WIDTH-1:0] out_data;

  assign cfg.ready = 1'b1;
  // result is sign-extended to the port width
  assign out_ch.sample_out = FIELD_W'(out_data);

  biquad_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_ch.sample_in[DATA_WIDTH-1:0]),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_data),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.wdata),
    .mac_ctrl   (mac_ctrl),
    .coef_op    (coef_op),
    .data_op    (data_op),
    .mac_result (mac_result)
  );

  biquad_mac #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .coef_op (coef_op),
    .data_op (data_op),
    .ctrl    (mac_ctrl),
    .result  (mac_result)
  );

endmodule

// ===== rtl/biquad_mac.sv =====
`timescale 1ns / 1ps

module biquad_mac import biquad_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic signed [COEF_W-1:0]     coef_op,
  input  logic signed [DATA_WIDTH-1:0] data_op,
  input  mac_ctrl_t                    ctrl,
  output logic signed [DATA_WIDTH-1:0] result
);

  localparam int PROD_W = COEF_W + DATA_WIDTH;
  // five products plus headroom
  localparam int ACC_W  = PROD_W + 3;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;

  always_ff @(posedge clk) begin
    prod <= coef_op * data_op;
    if (ctrl.add) begin
      acc <= acc_next;
    end
  end

  always_comb begin
    if (ctrl.clear) begin
      acc_next = ACC_W'(prod);
    end else begin
      acc_next = acc + ACC_W'(prod);
    end
  end

  // floor shift and wrap are one bit slice of the sum
  assign result = acc_next[FRAC_BITS +: DATA_WIDTH];

endmodule

// ===== rtl/biquad_ctrl.sv =====
`timescale 1ns / 1ps

module biquad_ctrl import biquad_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_data,
  input  logic                         cfg_valid,
  input  logic        [IDX_W-1:0]      cfg_index,
  input  logic signed [COEF_W-1:0]     cfg_data,
  output mac_ctrl_t                    mac_ctrl,
  output logic signed [COEF_W-1:0]     coef_op,
  output logic signed [DATA_WIDTH-1:0] data_op,
  input  logic signed [DATA_WIDTH-1:0] mac_result
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t                      state;
  logic [STEP_W-1:0]           step;
  logic signed [COEF_W-1:0]    coef_a0, coef_a1, coef_a2, coef_b1, coef_b2;
  logic signed [DATA_WIDTH-1:0] x0, y1_new;
  logic signed [DATA_WIDTH-1:0] xh0, xh1, fh0, fh1, sh0, sh1;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
      coef_a0   <= '0;
      coef_a1   <= '0;
      coef_a2   <= '0;
      coef_b1   <= '0;
      coef_b2   <= '0;
      xh0       <= '0;
      xh1       <= '0;
      fh0       <= '0;
      fh1       <= '0;
      sh0       <= '0;
      sh1       <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_A0:  coef_a0 <= cfg_data;
          REG_A1:  coef_a1 <= cfg_data;
          REG_A2:  coef_a2 <= cfg_data;
          REG_B1:  coef_b1 <= cfg_data;
          REG_B2:  coef_b2 <= cfg_data;
          default: ;
        endcase
      end

      // a new word loads when the output register is free or being taken
      if (state == ST_HOLD && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x0    <= in_data;
            step  <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          step <= step + 1'b1;
          if (step == CAP_S1) begin
            y1_new <= mac_result;
          end
          if (step == CAP_S2) begin
            // all history reads are done, shift the delay lines
            xh1   <= xh0;
            xh0   <= x0;
            fh1   <= fh0;
            fh0   <= y1_new;
            sh1   <= sh0;
            sh0   <= mac_result;
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid || out_ready) begin
            out_data <= sh0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // operand select; section two takes its new input last
  always_comb begin
    case (step)
      STEP_S1_X0: begin coef_op = coef_a0; data_op = x0;     end
      STEP_S1_X1: begin coef_op = coef_a1; data_op = xh0;    end
      STEP_S1_X2: begin coef_op = coef_a2; data_op = xh1;    end
      STEP_S1_Y1: begin coef_op = coef_b1; data_op = fh0;    end
      STEP_S1_Y2: begin coef_op = coef_b2; data_op = fh1;    end
      STEP_S2_X1: begin coef_op = coef_a1; data_op = fh0;    end
      STEP_S2_X2: begin coef_op = coef_a2; data_op = fh1;    end
      STEP_S2_Y1: begin coef_op = coef_b1; data_op = sh0;    end
      STEP_S2_Y2: begin coef_op = coef_b2; data_op = sh1;    end
      STEP_S2_X0: begin coef_op = coef_a0; data_op = y1_new; end
      default:    begin coef_op = '0;      data_op = '0;     end
    endcase
  end

  always_comb begin
    mac_ctrl.add   = (state == ST_RUN) && (step != STEP_S1_X0) && (step <= STEP_LAST);
    mac_ctrl.clear = (step == ACC_S1_FIRST) || (step == ACC_S2_FIRST);
  end

endmodule
